@@ src/rtw_pkg.sv @@
// Shared types and codes for the refreshable timer wheel.
`timescale 1ns / 1ps

package rtw_pkg;

    // Input kinds
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_ADDED     = 3'd0;
    localparam logic [2:0] STAT_BAD_DELAY = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_REFRESHED = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN   = 3'd4;
    localparam logic [2:0] STAT_EXPIRED   = 3'd5;
    localparam logic [2:0] STAT_TICK_DONE = 3'd6;

    // Wheel span after reset
    localparam logic [7:0] SPAN_RESET = 8'd60;

    // One timer entry as it travels around the ring
    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [7:0]  delay;
        logic [7:0]  ticks;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

endpackage

@@ src/rtw_cell.sv @@
// One ring cell holding a single timer entry.
`timescale 1ns / 1ps

module rtw_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift,
    input  rtw_pkg::entry_t d_in,
    output rtw_pkg::entry_t q
);

    rtw_pkg::entry_t entry_reg;

    // Valid bit: cleared by reset, loaded from the neighbor on shift
    // Payload: loaded from the neighbor on shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (shift) begin
            entry_reg.valid <= d_in.valid;
        end
        if (shift) begin
            entry_reg.id    <= d_in.id;
            entry_reg.delay <= d_in.delay;
            entry_reg.ticks <= d_in.ticks;
        end
    end

    assign q = entry_reg;

endmodule

@@ src/rtw_ctrl.sv @@
// Sequencer and head processing of the timer ring.
`timescale 1ns / 1ps

module rtw_ctrl #(
    parameter int TIMER_ENTRIES = 16,
    parameter int MAX_SPAN      = 255
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      span,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_kind,
    input  logic [31:0]     in_id,
    input  logic [7:0]      in_delay,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      out_status,
    output logic [31:0]     out_id,
    output logic            out_last,
    input  rtw_pkg::entry_t head_in,
    output rtw_pkg::entry_t head_out,
    output logic            shift
);

    localparam int STEP_W = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIMER_ENTRIES - 1);

    rtw_pkg::state_t state_reg, state_next;

    logic [1:0]        kind_reg, kind_next;
    logic [31:0]       id_reg, id_next;
    logic [7:0]        delay_reg, delay_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              match_found_reg, match_found_next;
    logic [STEP_W-1:0] match_slot_reg, match_slot_next;
    logic              free_found_reg, free_found_next;
    logic [STEP_W-1:0] free_slot_reg, free_slot_next;
    logic [2:0]        fin_reg, fin_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [31:0]       out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;

    logic [7:0]        span_eff;
    logic [7:0]        delay_eff;
    logic              bad_delay;
    logic              out_free;
    logic              last_step;
    logic              step_go;
    logic              emit;
    logic [2:0]        emit_status;
    logic [31:0]       emit_id;
    logic              emit_last;
    logic [7:0]        tick_dec;
    logic              expire;
    logic [STEP_W-1:0] target_slot;

    // Clamp the span and resolve the add delay
    always_comb begin
        span_eff = span;
        if (span_eff == 8'd0) begin
            span_eff = 8'd1;
        end
        if (span_eff > 8'(MAX_SPAN)) begin
            span_eff = 8'(MAX_SPAN);
        end
    end

    assign bad_delay = (in_delay > span_eff);
    assign delay_eff = (in_delay == 8'd0) ? span_eff : in_delay;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_step = (cnt_reg == LAST_STEP);
    assign in_ready  = (state_reg == rtw_pkg::ST_IDLE);
    assign target_slot = match_found_reg ? match_slot_reg : free_slot_reg;

    // Decrement the head entry for a tick
    assign tick_dec = (head_in.ticks != 8'd0) ? (head_in.ticks - 8'd1) : 8'd0;
    assign expire   = head_in.valid && (tick_dec == 8'd0);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtw_pkg::ST_IDLE: begin
                if (in_valid) begin
                    case (in_kind)
                        rtw_pkg::KIND_ADD: begin
                            state_next = bad_delay ? rtw_pkg::ST_FINISH : rtw_pkg::ST_SCAN;
                        end
                        rtw_pkg::KIND_REFRESH, rtw_pkg::KIND_TICK: begin
                            state_next = rtw_pkg::ST_SCAN;
                        end
                        default: begin
                            state_next = rtw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rtw_pkg::ST_SCAN: begin
                if (step_go && last_step) begin
                    if (kind_reg == rtw_pkg::KIND_ADD
                            && (match_found_next || free_found_next)) begin
                        state_next = rtw_pkg::ST_WRITE;
                    end else begin
                        state_next = rtw_pkg::ST_FINISH;
                    end
                end
            end
            rtw_pkg::ST_WRITE: begin
                if (last_step) begin
                    state_next = rtw_pkg::ST_FINISH;
                end
            end
            rtw_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rtw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtw_pkg::ST_IDLE;
            end
        endcase
    end

    // Head processing, step control and result selection
    always_comb begin
        head_out         = head_in;
        step_go          = 1'b0;
        emit             = 1'b0;
        emit_status      = rtw_pkg::STAT_TICK_DONE;
        emit_id          = 32'd0;
        emit_last        = 1'b0;
        kind_next        = kind_reg;
        id_next          = id_reg;
        delay_next       = delay_reg;
        cnt_next         = cnt_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        fin_next         = fin_reg;
        case (state_reg)
            rtw_pkg::ST_IDLE: begin
                // Latch the command and clear the scan results
                kind_next        = in_kind;
                id_next          = in_id;
                delay_next       = delay_eff;
                cnt_next         = '0;
                match_found_next = 1'b0;
                free_found_next  = 1'b0;
                fin_next         = rtw_pkg::STAT_BAD_DELAY;
            end
            rtw_pkg::ST_SCAN: begin
                step_go = 1'b1;
                case (kind_reg)
                    rtw_pkg::KIND_ADD: begin
                        // Find the live id and the lowest free entry
                        if (head_in.valid && head_in.id == id_reg && !match_found_reg) begin
                            match_found_next = 1'b1;
                            match_slot_next  = cnt_reg;
                        end
                        if (!head_in.valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_slot_next  = cnt_reg;
                        end
                        fin_next = rtw_pkg::STAT_FULL;
                    end
                    rtw_pkg::KIND_REFRESH: begin
                        // Restart the countdown of the live id
                        if (head_in.valid && head_in.id == id_reg) begin
                            head_out.ticks   = head_in.delay;
                            match_found_next = 1'b1;
                        end
                        fin_next = match_found_next ? rtw_pkg::STAT_REFRESHED
                                                    : rtw_pkg::STAT_UNKNOWN;
                    end
                    default: begin
                        // Tick: decrement, report and free expired entries
                        if (head_in.valid) begin
                            head_out.ticks = tick_dec;
                            head_out.valid = !expire;
                        end
                        step_go     = !expire || out_free;
                        emit        = expire && out_free;
                        emit_status = rtw_pkg::STAT_EXPIRED;
                        emit_id     = head_in.id;
                        fin_next    = rtw_pkg::STAT_TICK_DONE;
                    end
                endcase
                if (step_go) begin
                    cnt_next = last_step ? '0 : cnt_reg + 1'b1;
                end
            end
            rtw_pkg::ST_WRITE: begin
                // Drop the new timer into the chosen entry as it passes
                step_go = 1'b1;
                if (cnt_reg == target_slot) begin
                    head_out.valid = 1'b1;
                    head_out.id    = id_reg;
                    head_out.delay = delay_reg;
                    head_out.ticks = delay_reg;
                end
                fin_next = rtw_pkg::STAT_ADDED;
                cnt_next = last_step ? '0 : cnt_reg + 1'b1;
            end
            rtw_pkg::ST_FINISH: begin
                emit        = out_free;
                emit_status = fin_reg;
                emit_id     = 32'd0;
                emit_last   = 1'b1;
            end
            default: begin
                step_go = 1'b0;
            end
        endcase
    end

    assign shift = step_go;

    // Output register
    always_comb begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_id_next     = emit_id;
            out_last_next   = emit_last;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rtw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload registers
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        delay_reg       <= delay_next;
        cnt_reg         <= cnt_next;
        match_found_reg <= match_found_next;
        match_slot_reg  <= match_slot_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        fin_reg         <= fin_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_last   = out_last_reg;

`ifndef SYNTHESIS
    // The ring never moves while waiting for a command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rtw_pkg::ST_IDLE) |-> !shift)
        else $error("ring shifted while idle");

    // The write pass only runs with a target entry in hand
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rtw_pkg::ST_WRITE) |-> (match_found_reg || free_found_reg))
        else $error("write pass without target entry");

    // The closing result of a command is marked last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rtw_pkg::ST_FINISH && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("closing result not marked last");

    // An expiry result is never the last one of a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == rtw_pkg::STAT_EXPIRED) |-> !out_last_reg)
        else $error("expiry result marked last");
`endif

endmodule

@@ src/refreshable_timer_wheel_core.sv @@
// Each command passes the ring past the head: an add makes a scan pass and, if an entry was
// found, a write pass; a refresh or tick makes one pass and a rejected delay makes none.
// The ring rotates one cell per cycle past the head during a pass, except that a tick stalls
// on an expiry while a result waits on m_tready. One command at a time: the next transfer is
// taken in the cycle after the closing result is loaded, which itself waits on m_tready.
// Reset: synchronous active-low aresetn empties all entries and sets wheel_span to 60.
`timescale 1ns / 1ps

module refreshable_timer_wheel_core #(
    parameter int TIMER_ENTRIES = 16,
    parameter int MAX_SPAN      = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // wheel_span
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [31:0] task_id, [39:32] delay_ticks
    input  logic [1:0]  s_tuser,       // [1:0] kind
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] expired_id
    output logic [2:0]  m_tuser,       // [2:0] status
    output logic        m_tlast
);

    logic [7:0] span_reg;

    rtw_pkg::entry_t ring_q [TIMER_ENTRIES];
    rtw_pkg::entry_t ring_d [TIMER_ENTRIES];
    rtw_pkg::entry_t head_out;
    logic            shift;

    // Hold the wheel span register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg <= rtw_pkg::SPAN_RESET;
        end else if (cfg_valid) begin
            span_reg <= cfg_data;
        end
    end

    // Sequencer and head stage
    rtw_ctrl #(
        .TIMER_ENTRIES (TIMER_ENTRIES),
        .MAX_SPAN      (MAX_SPAN)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .span       (span_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_id      (s_tdata[31:0]),
        .in_delay   (s_tdata[39:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_id     (m_tdata),
        .out_last   (m_tlast),
        .head_in    (ring_q[0]),
        .head_out   (head_out),
        .shift      (shift)
    );

    // Ring of cells: each takes its upper neighbor, the top takes the head result
    for (genvar i = 0; i < TIMER_ENTRIES; i++) begin : g_cell
        if (i == TIMER_ENTRIES - 1) begin : g_top
            assign ring_d[i] = head_out;
        end else begin : g_mid
            assign ring_d[i] = ring_q[i+1];
        end

        rtw_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (shift),
            .d_in    (ring_d[i]),
            .q       (ring_q[i])
        );
    end

endmodule
